[rtl/core/lcnc_pkg.sv]
// Shared types, constants and digit functions for the Luhn card number classifier.
package lcnc_pkg;

    localparam int CARD_W     = 63;
    localparam int BCD_DIGITS = 19;
    localparam int DIGIT_W    = 4;
    localparam int BCD_W      = BCD_DIGITS * DIGIT_W;
    localparam int STEP_W     = $clog2(CARD_W);
    localparam int IDX_W      = $clog2(BCD_DIGITS);
    localparam int COUNT_W    = 5;

    typedef logic [DIGIT_W-1:0] digit_t;

    typedef enum logic [1:0] {
        VERDICT_INVALID    = 2'd0,
        VERDICT_MASTERCARD = 2'd1,
        VERDICT_AMEX       = 2'd2,
        VERDICT_VISA       = 2'd3
    } verdict_t;

    typedef struct packed {
        logic               done;
        verdict_t           verdict;
        logic [COUNT_W-1:0] digit_count;
        logic               luhn_ok;
    } scan_res_t;

    // A doubled digit with its two decimal digits added together.
    function automatic digit_t double_fold(input digit_t d);
        digit_t r;
        case (d)
            4'd0:    r = 4'd0;
            4'd1:    r = 4'd2;
            4'd2:    r = 4'd4;
            4'd3:    r = 4'd6;
            4'd4:    r = 4'd8;
            4'd5:    r = 4'd1;
            4'd6:    r = 4'd3;
            4'd7:    r = 4'd5;
            4'd8:    r = 4'd7;
            4'd9:    r = 4'd9;
            default: r = 4'd0;
        endcase
        return r;
    endfunction

    function automatic verdict_t classify(input digit_t hi, input digit_t lo);
        verdict_t v;
        v = VERDICT_INVALID;
        if (hi == 4'd5 && lo >= 4'd1 && lo <= 4'd5)
            v = VERDICT_MASTERCARD;
        else if (hi == 4'd3 && (lo == 4'd4 || lo == 4'd7))
            v = VERDICT_AMEX;
        else if (hi == 4'd4)
            v = VERDICT_VISA;
        return v;
    endfunction

endpackage

[rtl/core/lcnc_bcd_conv.sv]
// Bit-serial binary to decimal converter using shift and add-three.
module lcnc_bcd_conv
    import lcnc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [CARD_W-1:0] card_number,
    output logic              done,
    output logic [BCD_W-1:0]  bcd
);

    logic [CARD_W-1:0] bin_reg, bin_next;
    logic [BCD_W-1:0]  bcd_reg, bcd_next;
    logic [BCD_W-1:0]  adj;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;

    always_comb
    begin
        for (int k = 0; k < BCD_DIGITS; k++)
        begin
            if (bcd_reg[k*DIGIT_W +: DIGIT_W] >= 4'd5)
                adj[k*DIGIT_W +: DIGIT_W] = bcd_reg[k*DIGIT_W +: DIGIT_W] + 4'd3;
            else
                adj[k*DIGIT_W +: DIGIT_W] = bcd_reg[k*DIGIT_W +: DIGIT_W];
        end
    end

    always_comb
    begin
        bin_next  = bin_reg;
        bcd_next  = bcd_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            bin_next  = card_number;
            bcd_next  = '0;
            step_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            bin_next  = {bin_reg[CARD_W-2:0], 1'b0};
            bcd_next  = {adj[BCD_W-2:0], bin_reg[CARD_W-1]};
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(CARD_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    assign done = done_reg;
    assign bcd  = bcd_reg;

endmodule

[rtl/core/lcnc_digit_scan.sv]
// Digit scanner: counts digits, forms the Luhn sum and picks the two leading digits.
module lcnc_digit_scan
    import lcnc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [BCD_W-1:0] bcd,
    output scan_res_t        res
);

    logic [BCD_W-1:0]   digits_reg, digits_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    digit_t             sum_reg, sum_next;
    digit_t             prev_reg, prev_next;
    digit_t             hi_reg, hi_next;
    digit_t             lo_reg, lo_next;
    logic               busy_reg, busy_next;
    logic               fin_reg, fin_next;
    digit_t             cur;
    digit_t             addend;
    logic [DIGIT_W:0]   sum_wide;
    logic               len_ok;
    logic               pass;

    assign cur      = digits_reg[DIGIT_W-1:0];
    assign addend   = idx_reg[0] ? double_fold(cur) : cur;
    assign sum_wide = {1'b0, sum_reg} + {1'b0, addend};

    always_comb
    begin
        digits_next = digits_reg;
        idx_next    = idx_reg;
        count_next  = count_reg;
        sum_next    = sum_reg;
        prev_next   = prev_reg;
        hi_next     = hi_reg;
        lo_next     = lo_reg;
        busy_next   = busy_reg;
        fin_next    = fin_reg;
        if (start)
        begin
            digits_next = bcd;
            idx_next    = '0;
            count_next  = '0;
            sum_next    = '0;
            prev_next   = '0;
            hi_next     = '0;
            lo_next     = '0;
            busy_next   = 1'b1;
            fin_next    = 1'b0;
        end
        else if (busy_reg)
        begin
            digits_next = {{DIGIT_W{1'b0}}, digits_reg[BCD_W-1:DIGIT_W]};
            idx_next    = idx_reg + 1'b1;
            prev_next   = cur;
            if (sum_wide >= (DIGIT_W+1)'(10))
                sum_next = DIGIT_W'(sum_wide - (DIGIT_W+1)'(10));
            else
                sum_next = DIGIT_W'(sum_wide);
            if (cur != '0)
            begin
                count_next = COUNT_W'(idx_reg) + 1'b1;
                hi_next    = cur;
                lo_next    = prev_reg;
            end
            if (idx_reg == IDX_W'(BCD_DIGITS - 1))
            begin
                busy_next = 1'b0;
                fin_next  = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            fin_reg  <= 1'b0;
            idx_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            fin_reg  <= fin_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        digits_reg <= digits_next;
        count_reg  <= count_next;
        sum_reg    <= sum_next;
        prev_reg   <= prev_next;
        hi_reg     <= hi_next;
        lo_reg     <= lo_next;
    end

    assign len_ok = (count_reg == COUNT_W'(13)) || (count_reg == COUNT_W'(15))
                 || (count_reg == COUNT_W'(16));
    assign pass   = len_ok && (sum_reg == '0);

    always_comb
    begin
        res.done        = fin_reg;
        res.digit_count = count_reg;
        res.luhn_ok     = pass;
        res.verdict     = pass ? classify(hi_reg, lo_reg) : VERDICT_INVALID;
    end

endmodule

[rtl/core/luhn_card_number_classifier.sv]
// Top level of the Luhn card number classifier with handshake control and result register.
// Each card number passes from acceptance to result through bit-serial shift-and-add-three
// conversion to 19 decimal digits, a hand-off of the digits to the scanner, a walk of the
// digit scanner over the digits from the units upwards, and a load of the result register.
// The next item can be accepted in the cycle after that load. If the previous result is
// still waiting, the finished item is held in the scanner and the input stays stalled
// until the result register is free. One item is worked on at a time; a new item is
// accepted while the previous result still waits in the output register. The result gives
// the digit count, the Luhn flag (set only for 13, 15 or 16 digits with a sum divisible by
// ten) and the verdict.
module luhn_card_number_classifier
    import lcnc_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_ready,
    input  logic [CARD_W-1:0]  card_number,
    output logic               res_valid,
    input  logic               res_ready,
    output logic [1:0]         verdict,
    output logic [COUNT_W-1:0] digit_count,
    output logic               luhn_ok
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_CONV = 3'b010,
        S_SCAN = 3'b100
    } state_t;

    state_t             state_reg, state_next;
    logic               out_valid_reg, out_valid_next;
    verdict_t           verdict_reg;
    logic [COUNT_W-1:0] count_reg;
    logic               ok_reg;
    logic               accept;
    logic               conv_done;
    logic [BCD_W-1:0]   bcd;
    scan_res_t          scan_res;
    logic               load;

    assign req_ready = (state_reg == S_IDLE);
    assign accept    = req_valid && req_ready;
    assign load      = (state_reg == S_SCAN) && scan_res.done && (!out_valid_reg || res_ready);

    lcnc_bcd_conv u_conv (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (accept),
        .card_number (card_number),
        .done        (conv_done),
        .bcd         (bcd)
    );

    lcnc_digit_scan u_scan (
        .clk   (clk),
        .rst_n (rst_n),
        .start (conv_done),
        .bcd   (bcd),
        .res   (scan_res)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                    state_next = S_CONV;
            end
            S_CONV:
            begin
                if (conv_done)
                    state_next = S_SCAN;
            end
            S_SCAN:
            begin
                if (load)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (load)
            out_valid_next = 1'b1;
        else if (res_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            verdict_reg <= scan_res.verdict;
            count_reg   <= scan_res.digit_count;
            ok_reg      <= scan_res.luhn_ok;
        end
    end

    assign res_valid   = out_valid_reg;
    assign verdict     = verdict_reg;
    assign digit_count = count_reg;
    assign luhn_ok     = ok_reg;

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_reg))
        else $error("State register is not one-hot.");

    assert property (@(posedge clk) disable iff (!rst_n) accept |=> state_reg == S_CONV)
        else $error("Accepted item did not start conversion.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && !luhn_ok) |-> verdict == VERDICT_INVALID)
        else $error("Verdict given without a Luhn pass.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid && luhn_ok) |-> (digit_count == COUNT_W'(13)
            || digit_count == COUNT_W'(15) || digit_count == COUNT_W'(16)))
        else $error("Luhn pass reported for a disallowed length.");
`endif

endmodule
